// File: hw/rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg: shared types and constants for the Miller-Rabin round
// Beat layouts for both channels, field widths and the control state codes.
// ----------------------------------------------------------------------------
package mrr_pkg;

   // fixed field widths of the channel beats
   localparam int CANDIDATE_W        = 32;
   localparam int RANDOM_W           = 31;
   localparam int RANDOM_CNT_W       = $clog2(RANDOM_W);

   // default number of candidate bits taken as two's complement
   localparam int CANDIDATE_BITS_DEF = 32;

   typedef struct packed {
      logic signed [CANDIDATE_W-1:0] candidate;
      logic [RANDOM_W-1:0]           random_word;
   } mrr_req_type;

   typedef struct packed {
      logic probably_prime;
      logic base_case;
   } mrr_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_WITNESS,
      ST_SPLIT,
      ST_POW,
      ST_POW_ACC,
      ST_POW_BASE,
      ST_CHECK,
      ST_SQUARE,
      ST_DONE
   } mrr_state_type;

endpackage

// File: hw/rtl/mrr_modmul.sv
// ----------------------------------------------------------------------------
// mrr_modmul: bit-serial modular multiplier
// Computes (op_a * op_b) mod modulus, taking the multiplier bits MSB first;
// each bit is double-and-reduce, then add-and-reduce. Operands below modulus.
// ----------------------------------------------------------------------------
module mrr_modmul #(
   parameter int NB = mrr_pkg::CANDIDATE_BITS_DEF - 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NB-1:0] op_a,
   input  logic [NB-1:0] op_b,
   input  logic [NB-1:0] modulus,
   output logic          done,
   output logic [NB-1:0] product
);

   localparam int CW = $clog2(NB);

   logic [NB-1:0] a_ff, a_in;
   logic [NB-1:0] b_ff, b_in;
   logic [NB-1:0] acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          phase_ff, phase_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NB:0]   dbl;
   logic [NB:0]   sum;
   logic [NB:0]   wide;
   logic [NB:0]   mod_ext;

   // step: phase 0 doubles the accumulator, phase 1 adds a when the bit is set
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mod_ext  = {1'b0, modulus};
      dbl      = {acc_ff, 1'b0};
      sum      = {1'b0, acc_ff} + {1'b0, (b_ff[NB-1] ? a_ff : '0)};
      wide     = phase_ff ? sum : dbl;
      if (start) begin
         a_in     = op_a;
         b_in     = op_b;
         acc_in   = '0;
         cnt_in   = CW'(NB - 1);
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // reduce once: the step result stays below twice the modulus
         acc_in   = (wide >= mod_ext) ? NB'(wide - mod_ext) : wide[NB-1:0];
         phase_in = !phase_ff;
         if (phase_ff) begin
            b_in = {b_ff[NB-2:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // hold operands and accumulator
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("modmul started while busy");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (busy_ff || done_ff) |-> (acc_ff < modulus))
      else $error("modmul accumulator not reduced");

   a_mod_stable: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $stable(modulus))
      else $error("modulus changed during multiply");
`endif

endmodule

// File: hw/rtl/miller_rabin_round_top.sv
// ----------------------------------------------------------------------------
// miller_rabin_round_top: one Miller-Rabin round
// Takes a candidate and a random word, gives one probable-prime verdict.
// ----------------------------------------------------------------------------
//  channel | direction | beat            | handshake
//  req     | in        | mrr_req_type    | req_valid / req_stall
//  rsp     | out       | mrr_rsp_type    | rsp_valid / rsp_stall
//
//  Small values (n <= 4 or negative) go from the accepting edge straight to
//  ST_DONE and raise rsp_valid with no multiply. Others reduce the random
//  word into a witness, split n-1, then run the power and the squarings on
//  the serial multiplier (NB = CANDIDATE_BITS-1 bits), which dominates the
//  run time; at 32 bits the worst case is 60 multiplies. One candidate is in
//  work at a time; a new beat is taken while the previous result waits on
//  rsp_stall. Reset is synchronous and clears the controller and rsp_valid.
// ----------------------------------------------------------------------------
module miller_rabin_round_top #(
   parameter int CANDIDATE_BITS = mrr_pkg::CANDIDATE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mrr_pkg::mrr_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mrr_pkg::mrr_rsp_type rsp_data
);

   import mrr_pkg::*;

   localparam int NB = CANDIDATE_BITS - 1;
   localparam int SW = $clog2(NB);

   mrr_state_type         state_ff, state_in;
   logic [NB-1:0]         n_ff, n_in;
   logic [NB-1:0]         nm1_ff, nm1_in;
   logic [NB-1:0]         m_ff, m_in;
   logic [RANDOM_W-1:0]   rnd_ff, rnd_in;
   logic [NB-1:0]         rem_ff, rem_in;
   logic [RANDOM_CNT_W-1:0] rcnt_ff, rcnt_in;
   logic [NB-1:0]         base_ff, base_in;
   logic [NB-1:0]         acc_ff, acc_in;
   logic [NB-1:0]         d_ff, d_in;
   logic [SW-1:0]         cnt_ff, cnt_in;
   logic                  prime_ff, prime_in;
   logic                  basec_ff, basec_in;
   logic                  rsp_valid_ff;
   mrr_rsp_type           rsp_data_ff;

   logic [CANDIDATE_BITS-1:0] cand_bits;
   logic                  cand_neg;
   logic [NB-1:0]         raw;
   logic                  base_comp;
   logic                  base_prime;
   logic                  req_accept;
   logic                  rsp_load;
   logic [NB:0]           trial;
   logic [NB-1:0]         rem_next;
   logic                  mul_start;
   logic [NB-1:0]         mul_a;
   logic [NB-1:0]         mul_b;
   logic                  mul_done;
   logic [NB-1:0]         mul_prod;

   // decode the candidate and the small-value cases
   always_comb begin
      cand_bits  = req_data.candidate[CANDIDATE_BITS-1:0];
      cand_neg   = cand_bits[CANDIDATE_BITS-1];
      raw        = cand_bits[NB-1:0];
      base_comp  = cand_neg || (raw < NB'(2)) || (raw == NB'(4));
      base_prime = !cand_neg && ((raw == NB'(2)) || (raw == NB'(3)));
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // restoring remainder step: one random bit per cycle
   always_comb begin
      trial    = {rem_ff, rnd_ff[RANDOM_W-1]};
      rem_next = (trial >= {1'b0, m_ff}) ? NB'(trial - {1'b0, m_ff}) : trial[NB-1:0];
   end

   // next state and datapath control
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      nm1_in    = nm1_ff;
      m_in      = m_ff;
      rnd_in    = rnd_ff;
      rem_in    = rem_ff;
      rcnt_in   = rcnt_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      d_in      = d_ff;
      cnt_in    = cnt_ff;
      prime_in  = prime_ff;
      basec_in  = basec_ff;
      mul_start = 1'b0;
      mul_a     = acc_ff;
      mul_b     = base_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               n_in    = raw;
               nm1_in  = raw - NB'(1);
               m_in    = raw - NB'(4);
               rnd_in  = req_data.random_word;
               rem_in  = '0;
               rcnt_in = RANDOM_CNT_W'(RANDOM_W - 1);
               if (base_comp || base_prime) begin
                  prime_in = base_prime;
                  basec_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  prime_in = 1'b0;
                  basec_in = 1'b0;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            rem_in = rem_next;
            rnd_in = {rnd_ff[RANDOM_W-2:0], 1'b0};
            if (rcnt_ff == '0) begin
               state_in = ST_WITNESS;
            end else begin
               rcnt_in = rcnt_ff - RANDOM_CNT_W'(1);
            end
         end
         ST_WITNESS: begin
            // witness lands in [2, n-3]
            base_in  = rem_ff + NB'(2);
            acc_in   = NB'(1);
            d_in     = nm1_ff;
            cnt_in   = '0;
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            // strip trailing zeros of n-1, counting them
            if (!d_ff[0]) begin
               d_in   = {1'b0, d_ff[NB-1:1]};
               cnt_in = cnt_ff + SW'(1);
            end else begin
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            mul_start = 1'b1;
            if (d_ff[0]) begin
               mul_a    = acc_ff;
               mul_b    = base_ff;
               state_in = ST_POW_ACC;
            end else begin
               mul_a    = base_ff;
               mul_b    = base_ff;
               state_in = ST_POW_BASE;
            end
         end
         ST_POW_ACC: begin
            if (mul_done) begin
               acc_in = mul_prod;
               if (d_ff[NB-1:1] == '0) begin
                  state_in = ST_CHECK;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = base_ff;
                  mul_b     = base_ff;
                  state_in  = ST_POW_BASE;
               end
            end
         end
         ST_POW_BASE: begin
            if (mul_done) begin
               base_in  = mul_prod;
               d_in     = {1'b0, d_ff[NB-1:1]};
               state_in = ST_POW;
            end
         end
         ST_CHECK: begin
            if ((acc_ff == NB'(1)) || (acc_ff == nm1_ff)) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else if (cnt_ff < SW'(2)) begin
               state_in = ST_DONE;
            end else begin
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = acc_ff;
               cnt_in    = cnt_ff - SW'(1);
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               if (mul_prod == nm1_ff) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else if ((mul_prod == NB'(1)) || (cnt_ff < SW'(2))) begin
                  state_in = ST_DONE;
               end else begin
                  acc_in    = mul_prod;
                  mul_start = 1'b1;
                  mul_a     = mul_prod;
                  mul_b     = mul_prod;
                  cnt_in    = cnt_ff - SW'(1);
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // advance the controller
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the working values
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      nm1_ff   <= nm1_in;
      m_ff     <= m_in;
      rnd_ff   <= rnd_in;
      rem_ff   <= rem_in;
      rcnt_ff  <= rcnt_in;
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      d_ff     <= d_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
      basec_ff <= basec_in;
   end

   // result register: load on finish, drop once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.probably_prime <= prime_ff;
         rsp_data_ff.base_case      <= basec_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mrr_modmul #(
      .NB(NB)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (n_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

`ifndef ASSERT_OFF
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> ((state_ff == ST_POW_ACC) || (state_ff == ST_POW_BASE) ||
                    (state_ff == ST_SQUARE)))
      else $error("multiply finished outside a wait state");

   a_check_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (acc_ff < n_ff))
      else $error("power result not reduced");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE) |-> (rem_ff < m_ff))
      else $error("witness remainder out of range");

   a_split_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |-> (d_ff != '0))
      else $error("odd part of n-1 is zero");
`endif

endmodule
